FILE: rtl/iortr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// In-order retire task ring: shared package
// Field widths, ring geometry, operation and status codes, and the structs
// that pass between the control block and the entry store.
// ----------------------------------------------------------------------------
package iortr_pkg;

  localparam int IDX_W  = 7;
  localparam int CAP_W  = 8;
  localparam int ADDR_W = 48;
  localparam int LEN_W  = 17;

  // Number of entries in the store; the index fields are IDX_W bits wide.
  localparam int RING_DEPTH = 1 << IDX_W;

  localparam logic [LEN_W-1:0] MAX_CHUNK_BYTES = LEN_W'(65536);
  localparam logic [CAP_W-1:0] CAP_RESET       = CAP_W'(RING_DEPTH);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CAP_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef enum logic [1:0] {
    OP_SUBMIT   = 2'd0,
    OP_DRAIN    = 2'd1,
    OP_FETCH    = 2'd2,
    OP_COMPLETE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_RETIRED    = 3'd1,
    ST_DISPATCHED = 3'd2,
    ST_FULL       = 3'd3,
    ST_BUSY       = 3'd4,
    ST_EMPTY      = 3'd5,
    ST_COMPLETED  = 3'd6
  } status_e;

  // Write and read requests from the control block to the entry store.
  typedef struct packed {
    logic  desc_we;
    logic  lines_we;
    logic  done_we;
    logic  done_val;
    idx_t  wr_idx;
    addr_t wr_addr;
    len_t  wr_len;
    len_t  wr_lines;
    idx_t  rd_idx;
    idx_t  head_next;
  } store_req_t;

  // Registered result header and the input-side payload of one result.
  typedef struct packed {
    logic    valid;
    status_e status;
    idx_t    index;
    addr_t   addr;
    len_t    len;
    len_t    lines;
  } res_t;

  // Wraps a ring position once at the capacity, then into the store depth.
  function automatic idx_t wrap_idx(logic [CAP_W:0] x, cnt_t cap);
    logic [CAP_W:0] y;
    y = x;
    if (y >= {1'b0, cap}) begin
      y = y - {1'b0, cap};
    end
    return y[IDX_W-1:0];
  endfunction

endpackage

FILE: rtl/iortr_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// In-order retire task ring: entry store
// Descriptor, line count and done-flag memories with registered reads. The
// done memory is read at the next head so the head's flag is ready each cycle.
// ----------------------------------------------------------------------------
module iortr_store (
  input  logic                  clk_i,
  input  iortr_pkg::store_req_t req_i,
  output iortr_pkg::addr_t      rd_addr_o,
  output iortr_pkg::len_t       rd_len_o,
  output iortr_pkg::len_t       rd_lines_o,
  output logic                  head_done_o
);
  import iortr_pkg::*;

  logic [ADDR_W+LEN_W-1:0] desc_mem [RING_DEPTH];
  len_t                    lines_mem [RING_DEPTH];
  logic                    done_mem [RING_DEPTH];

  logic [ADDR_W+LEN_W-1:0] desc_rd_q;
  len_t                    lines_rd_q;
  logic                    head_done_q;

  always_ff @(posedge clk_i) begin
    if (req_i.desc_we) begin
      desc_mem[req_i.wr_idx] <= {req_i.wr_addr, req_i.wr_len};
    end
    if (req_i.lines_we) begin
      lines_mem[req_i.wr_idx] <= req_i.wr_lines;
    end
    desc_rd_q  <= desc_mem[req_i.rd_idx];
    lines_rd_q <= lines_mem[req_i.rd_idx];
  end

  // A flag written in the same cycle at the next head is forwarded.
  always_ff @(posedge clk_i) begin
    if (req_i.done_we) begin
      done_mem[req_i.wr_idx] <= req_i.done_val;
    end
    if (req_i.done_we && (req_i.wr_idx == req_i.head_next)) begin
      head_done_q <= req_i.done_val;
    end else begin
      head_done_q <= done_mem[req_i.head_next];
    end
  end

  assign rd_addr_o   = desc_rd_q[ADDR_W+LEN_W-1:LEN_W];
  assign rd_len_o    = desc_rd_q[LEN_W-1:0];
  assign rd_lines_o  = lines_rd_q;
  assign head_done_o = head_done_q;

endmodule

FILE: rtl/iortr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// In-order retire task ring: control
// Holds head, occupied and waiting counts and the capacity register, decides
// each operation in one pass and registers the result header.
// ----------------------------------------------------------------------------
module iortr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  iortr_pkg::op_e        op_i,
  input  iortr_pkg::addr_t      chunk_address_i,
  input  iortr_pkg::len_t       chunk_length_i,
  input  iortr_pkg::idx_t       task_index_i,
  input  iortr_pkg::len_t       line_count_in_i,
  input  logic                  cfg_we_i,
  input  iortr_pkg::cnt_t       cfg_data_i,
  input  logic                  head_done_i,
  output iortr_pkg::store_req_t req_o,
  output iortr_pkg::res_t       res_o
);
  import iortr_pkg::*;

  idx_t head_q, head_d;
  cnt_t occ_q, occ_d;
  cnt_t wait_q, wait_d;
  cnt_t cap_q;
  res_t res_q, res_d;

  cnt_t           cap;
  logic           retire;
  logic           full;
  idx_t           submit_slot;
  idx_t           fetch_slot;
  idx_t           head_inc;
  len_t           sat_len;
  logic [CAP_W:0] fetch_pos;

  always_comb begin
    if (cap_q == '0) begin
      cap = CAP_W'(1);
    end else if (cap_q > CAP_RESET) begin
      cap = CAP_RESET;
    end else begin
      cap = cap_q;
    end
  end

  // The waiting entries are the youngest ones, so wait never exceeds occ.
  assign fetch_pos   = {2'b00, head_q} + {1'b0, occ_q} - {1'b0, wait_q};
  assign submit_slot = wrap_idx({2'b00, head_q} + {1'b0, occ_q}, cap);
  assign fetch_slot  = wrap_idx(fetch_pos, cap);
  assign head_inc    = wrap_idx({2'b00, head_q} + (CAP_W+1)'(1), cap);
  assign retire      = (wait_q < occ_q) && head_done_i;
  assign full        = occ_q >= cap;
  assign sat_len     = (chunk_length_i > MAX_CHUNK_BYTES) ? MAX_CHUNK_BYTES : chunk_length_i;

  always_comb begin
    head_d = head_q;
    occ_d  = occ_q;
    wait_d = wait_q;

    req_o          = '0;
    req_o.wr_addr  = chunk_address_i;
    req_o.wr_len   = sat_len;
    req_o.wr_lines = line_count_in_i;
    req_o.rd_idx   = head_q;

    res_d        = res_q;
    res_d.valid  = 1'b0;

    if (accept_i) begin
      res_d.valid  = 1'b1;
      res_d.status = ST_EMPTY;
      res_d.index  = '0;
      res_d.addr   = chunk_address_i;
      res_d.len    = sat_len;
      res_d.lines  = line_count_in_i;
      case (op_i)
        OP_SUBMIT, OP_DRAIN: begin
          if (retire) begin
            res_d.status = ST_RETIRED;
            res_d.index  = head_q;
            head_d       = head_inc;
            occ_d        = occ_q - CAP_W'(1);
          end else if (op_i == OP_DRAIN) begin
            res_d.status = (occ_q != '0) ? ST_BUSY : ST_EMPTY;
          end else if (full) begin
            res_d.status = ST_FULL;
          end else begin
            res_d.status   = ST_ACCEPTED;
            res_d.index    = submit_slot;
            req_o.desc_we  = 1'b1;
            req_o.done_we  = 1'b1;
            req_o.done_val = 1'b0;
            req_o.wr_idx   = submit_slot;
            occ_d          = occ_q + CAP_W'(1);
            wait_d         = wait_q + CAP_W'(1);
          end
        end
        OP_FETCH: begin
          if (wait_q != '0) begin
            res_d.status = ST_DISPATCHED;
            res_d.index  = fetch_slot;
            req_o.rd_idx = fetch_slot;
            wait_d       = wait_q - CAP_W'(1);
          end
        end
        OP_COMPLETE: begin
          res_d.status   = ST_COMPLETED;
          res_d.index    = task_index_i;
          req_o.rd_idx   = task_index_i;
          req_o.wr_idx   = task_index_i;
          req_o.lines_we = 1'b1;
          req_o.done_we  = 1'b1;
          req_o.done_val = 1'b1;
        end
        default: begin
          res_d.status = ST_EMPTY;
        end
      endcase
    end

    req_o.head_next = head_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      occ_q  <= '0;
      wait_q <= '0;
      cap_q  <= CAP_RESET;
      res_q  <= '0;
    end else begin
      head_q <= head_d;
      occ_q  <= occ_d;
      wait_q <= wait_d;
      res_q  <= res_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  assign res_o = res_q;

endmodule

FILE: rtl/in_order_retire_task_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// In-order retire task ring
// Ring of chunk descriptors that are submitted in order, fetched by workers
// oldest-first, completed in any order and retired strictly in ring order.
// ----------------------------------------------------------------------------
// The block takes one operation per clock cycle and busy never rises, so a
// beat can be issued on every cycle. Each beat produces exactly one result
// beat, marked by valid_o in the cycle after the command is taken; results
// come out in command order and must be captured when valid_o is high,
// because the receiver cannot stall them. The entry store has registered
// read ports, and the decision and all state updates happen in the cycle
// the command is taken. Stall conditions of a software ring (ring full,
// head not done, nothing to fetch) are reported as status codes instead of
// waiting. There is no clearing pass after reset: the user must see that an
// entry is only read after it has been written, as the block does not
// check. The capacity register may be rewritten only while the block is
// idle; 0 acts as 1 and values above the store depth act as the depth.
// ----------------------------------------------------------------------------
module in_order_retire_task_ring (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               operation_i,
  input  logic [iortr_pkg::ADDR_W-1:0] chunk_address_i,
  input  logic [iortr_pkg::LEN_W-1:0]  chunk_length_i,
  input  logic [iortr_pkg::IDX_W-1:0]  task_index_i,
  input  logic [iortr_pkg::LEN_W-1:0]  line_count_in_i,
  input  logic                     cfg_we_i,
  input  logic [iortr_pkg::CAP_W-1:0]  cfg_data_i,
  output logic                     valid_o,
  output logic [2:0]               status_o,
  output logic [iortr_pkg::IDX_W-1:0]  index_out_o,
  output logic [iortr_pkg::ADDR_W-1:0] address_out_o,
  output logic [iortr_pkg::LEN_W-1:0]  length_out_o,
  output logic [iortr_pkg::LEN_W-1:0]  line_count_out_o
);
  import iortr_pkg::*;

  store_req_t req;
  res_t       res;
  addr_t      rd_addr;
  len_t       rd_len;
  len_t       rd_lines;
  logic       head_done;
  logic       accept;

  // Every operation completes in a single pass, so the block is never busy.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  iortr_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .op_i            (op_e'(operation_i)),
    .chunk_address_i (chunk_address_i),
    .chunk_length_i  (chunk_length_i),
    .task_index_i    (task_index_i),
    .line_count_in_i (line_count_in_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .head_done_i     (head_done),
    .req_o           (req),
    .res_o           (res)
  );

  iortr_store u_store (
    .clk_i       (clk_i),
    .req_i       (req),
    .rd_addr_o   (rd_addr),
    .rd_len_o    (rd_len),
    .rd_lines_o  (rd_lines),
    .head_done_o (head_done)
  );

  // The result beat combines the registered header with the stored entry, the
  // command's own payload or both, depending on the status.
  always_comb begin
    valid_o          = res.valid;
    status_o         = res.status;
    index_out_o      = res.index;
    address_out_o    = '0;
    length_out_o     = '0;
    line_count_out_o = '0;
    case (res.status)
      ST_RETIRED: begin
        address_out_o    = rd_addr;
        length_out_o     = rd_len;
        line_count_out_o = rd_lines;
      end
      ST_ACCEPTED: begin
        // A newly submitted entry echoes what was just stored.
        address_out_o = res.addr;
        length_out_o  = res.len;
      end
      ST_DISPATCHED: begin
        address_out_o = rd_addr;
        length_out_o  = rd_len;
      end
      ST_COMPLETED: begin
        address_out_o    = rd_addr;
        length_out_o     = rd_len;
        line_count_out_o = res.lines;
      end
      default: begin
        index_out_o = '0;
      end
    endcase
  end

endmodule
